### rtl/config_text_lexer_defines.svh
// Assertion macros shared by the lexer checker.
`ifndef CONFIG_TEXT_LEXER_DEFINES_SVH
`define CONFIG_TEXT_LEXER_DEFINES_SVH

// A clocked property checked outside reset; the caller supplies the whole property.
`define CFL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A stalled transaction keeps its valid and the given payload signal.
`define CFL_ASSERT_HOLD(label, vld, stl, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && stl) |=> (vld && $stable(sig))) else $error(msg);

`endif

### rtl/cfl_pkg.sv
// Types, codes and character helpers for the configuration text lexer.
package cfl_pkg;

  localparam int MAX_RES       = 3;
  localparam int RES_CNT_W     = $clog2(MAX_RES + 1);
  localparam int RES_DEPTH_DEF = 4;
  localparam int LINE_W        = 16;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_COMMENT = 5'b00010,
    MODE_NUMBER  = 5'b00100,
    MODE_IDENT   = 5'b01000,
    MODE_STRING  = 5'b10000
  } mode_t;

  typedef enum logic [2:0] {
    PEND_NONE        = 3'd0,
    PEND_BRACE_OPEN  = 3'd1,
    PEND_SLASH       = 3'd2,
    PEND_DOT         = 3'd3,
    PEND_BRACE_CLOSE = 3'd4
  } pend_t;

  typedef enum logic [1:0] {
    DELIM_DQUOTE = 2'd0,
    DELIM_SQUOTE = 2'd1,
    DELIM_BRACES = 2'd2
  } delim_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_CHAR    = 2'd1,
    ERR_UNTERM  = 2'd2
  } err_t;

  typedef enum logic [3:0] {
    KIND_NUMBER = 4'd0,
    KIND_IDENT  = 4'd1,
    KIND_STRING = 4'd2,
    KIND_OPEN   = 4'd3,
    KIND_CLOSE  = 4'd4,
    KIND_COLON  = 4'd5,
    KIND_COMMA  = 4'd6,
    KIND_SEMI   = 4'd7,
    KIND_NONE   = 4'd8
  } kind_t;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    kind_t              kind;
    logic               char_valid;
    logic [7:0]         token_char;
    logic               first;
    logic               last;
    logic [LINE_W-1:0]  line;
    err_t               err;
    logic               run_last;
  } result_t;

  // What a byte does when it is lexed from the idle state.
  typedef struct packed {
    logic   has_res;
    kind_t  kind;
    logic   cv;
    logic   first;
    logic   last;
    err_t   err;
    mode_t  mode;
    pend_t  pend;
    logic   start_str;
    delim_t delim;
    logic   set_err;
  } idle_act_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_ident_tail(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == CH_DASH) || (b == CH_DOLLAR) ||
           (b == CH_UNDER);
  endfunction

  function automatic result_t mk_res(input kind_t kind, input logic cv,
                                     input logic [7:0] ch, input logic first,
                                     input logic last, input err_t err,
                                     input logic [LINE_W-1:0] line);
    result_t r;
    r.kind       = kind;
    r.char_valid = cv;
    r.token_char = cv ? ch : 8'h00;
    r.first      = first;
    r.last       = last;
    r.line       = line;
    r.err        = err;
    r.run_last   = 1'b0;
    return r;
  endfunction

  function automatic idle_act_t punct(input kind_t kind);
    idle_act_t a;
    a           = '0;
    a.has_res   = 1'b1;
    a.kind      = kind;
    a.first     = 1'b1;
    a.last      = 1'b1;
    a.err       = ERR_NONE;
    a.mode      = MODE_IDLE;
    a.pend      = PEND_NONE;
    a.delim     = DELIM_DQUOTE;
    return a;
  endfunction

  function automatic idle_act_t idle_decode(input logic [7:0] b);
    idle_act_t a;
    a       = '0;
    a.kind  = KIND_NONE;
    a.err   = ERR_NONE;
    a.mode  = MODE_IDLE;
    a.pend  = PEND_NONE;
    a.delim = DELIM_DQUOTE;
    if (!is_space(b)) begin
      unique case (b) inside
        CH_HASH:   a.mode = MODE_COMMENT;
        CH_SLASH:  a.pend = PEND_SLASH;
        CH_LBRACE: a.pend = PEND_BRACE_OPEN;
        CH_RBRACE: a = punct(KIND_CLOSE);
        CH_COLON:  a = punct(KIND_COLON);
        CH_COMMA:  a = punct(KIND_COMMA);
        CH_SEMI:   a = punct(KIND_SEMI);
        CH_DQUOTE, CH_SQUOTE: begin
          a.has_res   = 1'b1;
          a.kind      = KIND_STRING;
          a.first     = 1'b1;
          a.mode      = MODE_STRING;
          a.start_str = 1'b1;
          a.delim     = (b == CH_DQUOTE) ? DELIM_DQUOTE : DELIM_SQUOTE;
        end
        default: begin
          a.has_res = 1'b1;
          if (is_digit(b)) begin
            a.kind  = KIND_NUMBER;
            a.cv    = 1'b1;
            a.first = 1'b1;
            a.mode  = MODE_NUMBER;
          end else if (is_alpha(b)) begin
            a.kind  = KIND_IDENT;
            a.cv    = 1'b1;
            a.first = 1'b1;
            a.mode  = MODE_IDENT;
          end else begin
            a.kind    = KIND_NONE;
            a.err     = ERR_CHAR;
            a.set_err = 1'b1;
          end
        end
      endcase
    end
    return a;
  endfunction

endpackage

### rtl/cfl_result_fifo.sv
// Result queue: takes up to three results in one cycle, hands out one per transaction.
module cfl_result_fifo #(
  parameter int DEPTH = cfl_pkg::RES_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [cfl_pkg::RES_CNT_W-1:0]        push_cnt,
  input  cfl_pkg::result_t                     push_res [cfl_pkg::MAX_RES],
  output logic                                 space_ok,
  output logic                                 head_valid,
  input  logic                                 pop,
  output cfl_pkg::result_t                     head
);
  import cfl_pkg::*;

  // DEPTH is a power of two of at least four so that the pointers wrap by themselves.
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t          mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(push_cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (RES_CNT_W'(k) < push_cnt) begin
        mem_r[wr_ptr_r + PTR_W'(k)] <= push_res[k];
      end
    end
  end

  assign space_ok   = (count_r <= CNT_W'(DEPTH - MAX_RES));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

endmodule

### rtl/cfl_step.sv
// Lexer state and the per-byte step logic that produces up to three results.
module cfl_step (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step_en,
  input  logic [7:0]                     text_byte,
  input  logic                           end_of_text,
  output cfl_pkg::result_t               res [cfl_pkg::MAX_RES],
  output logic [cfl_pkg::RES_CNT_W-1:0]  res_cnt
);
  import cfl_pkg::*;

  mode_t             mode_r, mode_nxt;
  delim_t            delim_r, delim_nxt;
  pend_t             pend_r, pend_nxt;
  logic              esc_r, esc_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              err_r, err_nxt;

  idle_act_t             ia;
  result_t               res_c [MAX_RES];
  logic [RES_CNT_W-1:0]  n_c;
  logic                  do_idle;
  logic                  do_raise;
  err_t                  raise_code;
  logic                  close_delim;

  assign ia = idle_decode(text_byte);

  always_comb begin
    mode_nxt   = mode_r;
    delim_nxt  = delim_r;
    pend_nxt   = pend_r;
    esc_nxt    = esc_r;
    line_nxt   = line_r;
    err_nxt    = err_r;
    n_c        = '0;
    do_idle    = 1'b0;
    do_raise   = 1'b0;
    raise_code = ERR_NONE;
    for (int k = 0; k < MAX_RES; k++) begin
      res_c[k] = '0;
    end
    close_delim = ((delim_r == DELIM_DQUOTE) && (text_byte == CH_DQUOTE)) ||
                  ((delim_r == DELIM_SQUOTE) && (text_byte == CH_SQUOTE));

    if (err_r) begin
      // The lexer stays silent until reset once an error has been reported.
    end else if (end_of_text) begin
      unique case (mode_r)
        MODE_NUMBER: begin
          res_c[n_c] = mk_res(KIND_NUMBER, 1'b0, 8'h00, 1'b0, 1'b1, ERR_NONE, line_r);
          n_c = n_c + 1'b1;
          if (pend_r == PEND_DOT) begin
            do_raise   = 1'b1;
            raise_code = ERR_CHAR;
          end
        end
        MODE_IDENT: begin
          res_c[n_c] = mk_res(KIND_IDENT, 1'b0, 8'h00, 1'b0, 1'b1, ERR_NONE, line_r);
          n_c = n_c + 1'b1;
        end
        MODE_STRING: begin
          do_raise   = 1'b1;
          raise_code = ERR_UNTERM;
        end
        MODE_IDLE: begin
          if (pend_r == PEND_BRACE_OPEN) begin
            res_c[n_c] = mk_res(KIND_OPEN, 1'b0, 8'h00, 1'b1, 1'b1, ERR_NONE, line_r);
            n_c = n_c + 1'b1;
          end else if (pend_r == PEND_SLASH) begin
            do_raise   = 1'b1;
            raise_code = ERR_CHAR;
          end
        end
        default: ;
      endcase
      mode_nxt = MODE_IDLE;
      pend_nxt = PEND_NONE;
      esc_nxt  = 1'b0;
    end else begin
      unique case (mode_r)
        MODE_IDLE: begin
          pend_nxt = PEND_NONE;
          if (pend_r == PEND_BRACE_OPEN) begin
            if (text_byte == CH_LBRACE) begin
              mode_nxt   = MODE_STRING;
              delim_nxt  = DELIM_BRACES;
              esc_nxt    = 1'b0;
              res_c[n_c] = mk_res(KIND_STRING, 1'b0, 8'h00, 1'b1, 1'b0, ERR_NONE, line_r);
              n_c = n_c + 1'b1;
            end else begin
              res_c[n_c] = mk_res(KIND_OPEN, 1'b0, 8'h00, 1'b1, 1'b1, ERR_NONE, line_r);
              n_c = n_c + 1'b1;
              do_idle = 1'b1;
            end
          end else if (pend_r == PEND_SLASH) begin
            if (text_byte == CH_SLASH) begin
              mode_nxt = MODE_COMMENT;
            end else begin
              do_raise   = 1'b1;
              raise_code = ERR_CHAR;
            end
          end else begin
            do_idle = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (text_byte == CH_LF) begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_NUMBER: begin
          if (pend_r == PEND_DOT) begin
            pend_nxt = PEND_NONE;
            if (is_digit(text_byte)) begin
              res_c[n_c] = mk_res(KIND_NUMBER, 1'b1, CH_DOT, 1'b0, 1'b0, ERR_NONE, line_r);
              n_c = n_c + 1'b1;
              res_c[n_c] = mk_res(KIND_NUMBER, 1'b1, text_byte, 1'b0, 1'b0, ERR_NONE,
                                  line_r);
              n_c = n_c + 1'b1;
            end else begin
              res_c[n_c] = mk_res(KIND_NUMBER, 1'b0, 8'h00, 1'b0, 1'b1, ERR_NONE, line_r);
              n_c = n_c + 1'b1;
              do_raise   = 1'b1;
              raise_code = ERR_CHAR;
            end
          end else if (is_digit(text_byte)) begin
            res_c[n_c] = mk_res(KIND_NUMBER, 1'b1, text_byte, 1'b0, 1'b0, ERR_NONE, line_r);
            n_c = n_c + 1'b1;
          end else if (text_byte == CH_DOT) begin
            pend_nxt = PEND_DOT;
          end else begin
            res_c[n_c] = mk_res(KIND_NUMBER, 1'b0, 8'h00, 1'b0, 1'b1, ERR_NONE, line_r);
            n_c = n_c + 1'b1;
            do_idle = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_ident_tail(text_byte)) begin
            res_c[n_c] = mk_res(KIND_IDENT, 1'b1, text_byte, 1'b0, 1'b0, ERR_NONE, line_r);
            n_c = n_c + 1'b1;
          end else begin
            res_c[n_c] = mk_res(KIND_IDENT, 1'b0, 8'h00, 1'b0, 1'b1, ERR_NONE, line_r);
            n_c = n_c + 1'b1;
            do_idle = 1'b1;
          end
        end
        MODE_STRING: begin
          if ((pend_r == PEND_BRACE_CLOSE) && (text_byte == CH_RBRACE)) begin
            pend_nxt   = PEND_NONE;
            mode_nxt   = MODE_IDLE;
            res_c[n_c] = mk_res(KIND_STRING, 1'b0, 8'h00, 1'b0, 1'b1, ERR_NONE, line_r);
            n_c = n_c + 1'b1;
          end else begin
            // A single closing brace inside a braced string is content.
            if (pend_r == PEND_BRACE_CLOSE) begin
              pend_nxt   = PEND_NONE;
              res_c[n_c] = mk_res(KIND_STRING, 1'b1, CH_RBRACE, 1'b0, 1'b0, ERR_NONE,
                                  line_r);
              n_c = n_c + 1'b1;
            end
            if (esc_r) begin
              esc_nxt    = 1'b0;
              res_c[n_c] = mk_res(KIND_STRING, 1'b1, text_byte, 1'b0, 1'b0, ERR_NONE,
                                  line_r);
              n_c = n_c + 1'b1;
            end else if (text_byte == CH_BSLASH) begin
              esc_nxt = 1'b1;
            end else if (close_delim) begin
              mode_nxt   = MODE_IDLE;
              res_c[n_c] = mk_res(KIND_STRING, 1'b0, 8'h00, 1'b0, 1'b1, ERR_NONE, line_r);
              n_c = n_c + 1'b1;
            end else if ((delim_r == DELIM_BRACES) && (text_byte == CH_RBRACE)) begin
              pend_nxt = PEND_BRACE_CLOSE;
            end else begin
              res_c[n_c] = mk_res(KIND_STRING, 1'b1, text_byte, 1'b0, 1'b0, ERR_NONE,
                                  line_r);
              n_c = n_c + 1'b1;
            end
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
          pend_nxt = PEND_NONE;
          do_idle  = 1'b1;
        end
      endcase
    end

    // Lexing from the idle state is always the last action of a byte.
    if (do_idle) begin
      if (ia.has_res) begin
        res_c[n_c] = mk_res(ia.kind, ia.cv, text_byte, ia.first, ia.last, ia.err, line_r);
        n_c = n_c + 1'b1;
      end
      mode_nxt = ia.mode;
      pend_nxt = ia.pend;
      esc_nxt  = 1'b0;
      if (ia.start_str) begin
        delim_nxt = ia.delim;
      end
      if (ia.set_err) begin
        err_nxt = 1'b1;
      end
    end

    if (do_raise) begin
      res_c[n_c] = mk_res(KIND_NONE, 1'b0, 8'h00, 1'b0, 1'b0, raise_code, line_r);
      n_c = n_c + 1'b1;
      err_nxt  = 1'b1;
      mode_nxt = MODE_IDLE;
      pend_nxt = PEND_NONE;
      esc_nxt  = 1'b0;
    end

    // A newline counts only after its results, and not when it caused an error.
    if (!err_r && !end_of_text && !err_nxt && (text_byte == CH_LF) && (line_r != '1)) begin
      line_nxt = line_r + 1'b1;
    end

    if (n_c != '0) begin
      res_c[n_c - 1'b1].run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      delim_r <= DELIM_DQUOTE;
      pend_r  <= PEND_NONE;
      esc_r   <= 1'b0;
      line_r  <= LINE_W'(1);
      err_r   <= 1'b0;
    end else if (step_en) begin
      mode_r  <= mode_nxt;
      delim_r <= delim_nxt;
      pend_r  <= pend_nxt;
      esc_r   <= esc_nxt;
      line_r  <= line_nxt;
      err_r   <= err_nxt;
    end
  end

  assign res     = res_c;
  assign res_cnt = n_c;

endmodule

### rtl/config_text_lexer.sv
// Configuration text lexer: one source byte per transaction in, token results out.
//
// The lexer takes one byte per cycle unless stalled. Each byte is lexed in the
// cycle it is accepted and yields zero to three results, which go into a result
// queue of RES_DEPTH entries; the result side drains one result per cycle unless
// out_stall holds it. The input stalls whenever fewer than three queue entries are
// free, so bytes that give at most one result stream at one per cycle, and a byte
// that gives n results uses n result transfers. Line numbers start at one and
// saturate; after an error result the lexer produces nothing more until reset.
module config_text_lexer #(
  parameter int RES_DEPTH = cfl_pkg::RES_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_kind,
  output logic        out_char_valid,
  output logic [7:0]  out_token_char,
  output logic        out_token_first,
  output logic        out_token_last,
  output logic [15:0] out_line_number,
  output logic [1:0]  out_error_code,
  output logic        out_run_last
);
  import cfl_pkg::*;

  logic                 in_accept;
  logic                 space_ok;
  logic                 pop;
  result_t              step_res [MAX_RES];
  logic [RES_CNT_W-1:0] step_cnt;
  logic [RES_CNT_W-1:0] push_cnt;
  result_t              head;

  assign in_stall  = !space_ok;
  assign in_accept = in_valid && !in_stall;
  assign push_cnt  = in_accept ? step_cnt : '0;
  assign pop       = out_valid && !out_stall;

  cfl_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (in_accept),
    .text_byte   (in_text_byte),
    .end_of_text (in_end_of_text),
    .res         (step_res),
    .res_cnt     (step_cnt)
  );

  cfl_result_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_result_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push_res   (step_res),
    .space_ok   (space_ok),
    .head_valid (out_valid),
    .pop        (pop),
    .head       (head)
  );

  assign out_token_kind  = head.kind;
  assign out_char_valid  = head.char_valid;
  assign out_token_char  = head.token_char;
  assign out_token_first = head.first;
  assign out_token_last  = head.last;
  assign out_line_number = head.line;
  assign out_error_code  = head.err;
  assign out_run_last    = head.run_last;

endmodule

### rtl/cfl_checker.sv
// Port-level checker for the configuration text lexer and its bind.
`include "config_text_lexer_defines.svh"

module cfl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_text_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_token_kind,
  input logic        out_char_valid,
  input logic [7:0]  out_token_char,
  input logic [15:0] out_line_number,
  input logic [1:0]  out_error_code
);
  import cfl_pkg::*;

  logic        out_take;
  logic        err_shown;
  logic        kind_carries;
  logic [15:0] shown_line;

  assign out_take     = out_valid && !out_stall;
  assign err_shown    = (out_error_code != ERR_NONE);
  assign kind_carries = (out_token_kind == KIND_NUMBER) || (out_token_kind == KIND_IDENT) ||
                        (out_token_kind == KIND_STRING);
  assign shown_line   = out_line_number;

  `CFL_ASSERT_HOLD(a_in_hold, in_valid, in_stall, in_text_byte, "stalled byte changed")

  `CFL_ASSERT_HOLD(a_out_hold, out_valid, out_stall, out_token_char, "stalled result changed")

  // An error result is the final result until reset.
  `CFL_ASSERT(a_err_final, (out_take && err_shown) |=> !out_valid, "result after error")

  // Line numbers never fall from one delivered result to the next.
  `CFL_ASSERT(a_line_mono, out_take ##1 out_valid |-> shown_line >= $past(shown_line), "line went back")

  // Content bytes belong only to number, identifier and string results.
  `CFL_ASSERT(a_char_kind, (out_valid && out_char_valid) |-> (!err_shown && kind_carries), "bad char")

endmodule

bind config_text_lexer cfl_checker u_cfl_checker (.*);

### test/tb_config_text_lexer.sv
// Self-checking testbench for the configuration text lexer: byte stream in, token results checked.
module tb_config_text_lexer;
  timeunit 1ns;
  timeprecision 1ps;

  import cfl_pkg::*;

  localparam int CYCLE_LIMIT   = 60000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 360;

  // Tracks the lexer state and holds the token results that are still owed.
  class token_tracker;
    mode_t       mode;
    delim_t      delim;
    pend_t       pend;
    bit          esc;
    logic [15:0] line;
    bit          dead;
    result_t     due[$];
    result_t     step_res[$];
    int          n_checked;
    int          n_bad;
    err_t        seen_err;

    function new();
      mode     = MODE_IDLE;
      delim    = DELIM_DQUOTE;
      pend     = PEND_NONE;
      esc      = 1'b0;
      line     = 16'd1;
      dead     = 1'b0;
      seen_err = ERR_NONE;
    endfunction

    function bit digit_byte(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function bit letter_byte(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function bit blank_byte(logic [7:0] b);
      return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function bit name_byte(logic [7:0] b);
      return letter_byte(b) || digit_byte(b) || b == CH_DASH || b == CH_DOLLAR ||
             b == CH_UNDER;
    endfunction

    function void put(kind_t k, bit cv, logic [7:0] ch, bit first, bit last, err_t e);
      result_t r;
      if (step_res.size() >= 3) return;
      r.kind       = k;
      r.char_valid = cv;
      r.token_char = cv ? ch : 8'h00;
      r.first      = first;
      r.last       = last;
      r.line       = line;
      r.err        = e;
      r.run_last   = 1'b0;
      step_res.insert(step_res.size(), r);
    endfunction

    function void punct(kind_t k);
      put(k, 1'b0, 8'h00, 1'b1, 1'b1, ERR_NONE);
    endfunction

    function void close_tok(kind_t k);
      put(k, 1'b0, 8'h00, 1'b0, 1'b1, ERR_NONE);
    endfunction

    function void content(kind_t k, logic [7:0] b);
      put(k, 1'b1, b, 1'b0, 1'b0, ERR_NONE);
    endfunction

    function void fail_with(err_t e);
      put(KIND_NONE, 1'b0, 8'h00, 1'b0, 1'b0, e);
      dead = 1'b1;
      mode = MODE_IDLE;
      pend = PEND_NONE;
      esc  = 1'b0;
    endfunction

    function void open_string(delim_t d);
      mode  = MODE_STRING;
      delim = d;
      esc   = 1'b0;
      pend  = PEND_NONE;
      put(KIND_STRING, 1'b0, 8'h00, 1'b1, 1'b0, ERR_NONE);
    endfunction

    function void idle_lex(logic [7:0] b);
      if (blank_byte(b)) return;
      case (b)
        CH_HASH:   mode = MODE_COMMENT;
        CH_SLASH:  pend = PEND_SLASH;
        CH_LBRACE: pend = PEND_BRACE_OPEN;
        CH_RBRACE: punct(KIND_CLOSE);
        CH_COLON:  punct(KIND_COLON);
        CH_COMMA:  punct(KIND_COMMA);
        CH_SEMI:   punct(KIND_SEMI);
        CH_DQUOTE: open_string(DELIM_DQUOTE);
        CH_SQUOTE: open_string(DELIM_SQUOTE);
        default: begin
          if (digit_byte(b)) begin
            mode = MODE_NUMBER;
            put(KIND_NUMBER, 1'b1, b, 1'b1, 1'b0, ERR_NONE);
          end else if (letter_byte(b)) begin
            mode = MODE_IDENT;
            put(KIND_IDENT, 1'b1, b, 1'b1, 1'b0, ERR_NONE);
          end else begin
            fail_with(ERR_CHAR);
          end
        end
      endcase
    endfunction

    function void string_lex(logic [7:0] b);
      if (esc) begin
        esc = 1'b0;
        content(KIND_STRING, b);
        return;
      end
      if (b == CH_BSLASH) begin
        esc = 1'b1;
        return;
      end
      if ((delim == DELIM_DQUOTE && b == CH_DQUOTE) ||
          (delim == DELIM_SQUOTE && b == CH_SQUOTE)) begin
        close_tok(KIND_STRING);
        mode = MODE_IDLE;
        return;
      end
      if (delim == DELIM_BRACES && b == CH_RBRACE) begin
        pend = PEND_BRACE_CLOSE;
        return;
      end
      content(KIND_STRING, b);
    endfunction

    function void end_text();
      case (mode)
        MODE_NUMBER: begin
          close_tok(KIND_NUMBER);
          if (pend == PEND_DOT) fail_with(ERR_CHAR);
        end
        MODE_IDENT:  close_tok(KIND_IDENT);
        MODE_STRING: fail_with(ERR_UNTERM);
        MODE_IDLE: begin
          if (pend == PEND_BRACE_OPEN) punct(KIND_OPEN);
          else if (pend == PEND_SLASH) fail_with(ERR_CHAR);
        end
        default: ;
      endcase
      mode = MODE_IDLE;
      pend = PEND_NONE;
      esc  = 1'b0;
    endfunction

    function void lex_byte(logic [7:0] b);
      pend_t p;
      p = pend;
      case (mode)
        MODE_IDLE: begin
          pend = PEND_NONE;
          if (p == PEND_BRACE_OPEN) begin
            if (b == CH_LBRACE) begin
              open_string(DELIM_BRACES);
            end else begin
              punct(KIND_OPEN);
              idle_lex(b);
            end
          end else if (p == PEND_SLASH) begin
            if (b == CH_SLASH) mode = MODE_COMMENT;
            else fail_with(ERR_CHAR);
          end else begin
            idle_lex(b);
          end
        end
        MODE_COMMENT: if (b == CH_LF) mode = MODE_IDLE;
        MODE_NUMBER: begin
          if (p == PEND_DOT) begin
            // A held dot belongs to the number only when a digit follows it.
            pend = PEND_NONE;
            if (digit_byte(b)) begin
              content(KIND_NUMBER, CH_DOT);
              content(KIND_NUMBER, b);
            end else begin
              close_tok(KIND_NUMBER);
              fail_with(ERR_CHAR);
            end
          end else if (digit_byte(b)) begin
            content(KIND_NUMBER, b);
          end else if (b == CH_DOT) begin
            pend = PEND_DOT;
          end else begin
            close_tok(KIND_NUMBER);
            mode = MODE_IDLE;
            idle_lex(b);
          end
        end
        MODE_IDENT: begin
          if (name_byte(b)) begin
            content(KIND_IDENT, b);
          end else begin
            close_tok(KIND_IDENT);
            mode = MODE_IDLE;
            idle_lex(b);
          end
        end
        MODE_STRING: begin
          if (p == PEND_BRACE_CLOSE) begin
            pend = PEND_NONE;
            if (b == CH_RBRACE) begin
              close_tok(KIND_STRING);
              mode = MODE_IDLE;
            end else begin
              content(KIND_STRING, CH_RBRACE);
              string_lex(b);
            end
          end else begin
            string_lex(b);
          end
        end
        default: begin
          mode = MODE_IDLE;
          pend = PEND_NONE;
          idle_lex(b);
        end
      endcase
    endfunction

    // Called for every accepted input transaction.
    function void take_byte(logic [7:0] b, bit eot);
      if (dead) return;
      step_res.delete();
      if (eot) begin
        end_text();
      end else begin
        lex_byte(b);
        if (!dead && b == CH_LF && line != 16'hFFFF) line++;
      end
      if (step_res.size() > 0) step_res[step_res.size() - 1].run_last = 1'b1;
      foreach (step_res[i]) due.insert(due.size(), step_res[i]);
    endfunction

    function void report(string msg);
      if (n_bad < 10) $display("MISMATCH at %0t: %s", $realtime, msg);
      n_bad++;
    endfunction

    function void check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("result %0d, %s: expected %0h, got %0h", n_checked, name, want, got));
    endfunction

    // Called for every accepted result transaction.
    function void match_token(result_t got);
      result_t want;
      if (due.size() == 0) begin
        report($sformatf("result with none expected: kind %0h char %0h err %0h",
                         got.kind, got.token_char, got.err));
        return;
      end
      want = due.pop_front();
      n_checked++;
      if (got.err != ERR_NONE) seen_err = got.err;
      check_field("token_kind", 16'(got.kind), 16'(want.kind));
      check_field("char_valid", 16'(got.char_valid), 16'(want.char_valid));
      check_field("token_char", 16'(got.token_char), 16'(want.token_char));
      check_field("token_first", 16'(got.first), 16'(want.first));
      check_field("token_last", 16'(got.last), 16'(want.last));
      check_field("line_number", got.line, want.line);
      check_field("error_code", 16'(got.err), 16'(want.err));
      check_field("run_last", 16'(got.run_last), 16'(want.run_last));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_text_byte;
  logic        in_end_of_text;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_token_kind;
  logic        out_char_valid;
  logic [7:0]  out_token_char;
  logic        out_token_first;
  logic        out_token_last;
  logic [15:0] out_line_number;
  logic [1:0]  out_error_code;
  logic        out_run_last;

  token_tracker book;
  logic [8:0]   src[$];   // bit 8 marks an end-of-text transaction
  int           send_gap_pct;
  int           stall_pct;
  int           hold_left;
  int           n_sent;
  int           cycle_count;

  config_text_lexer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_token_kind  (out_token_kind),
    .out_char_valid  (out_char_valid),
    .out_token_char  (out_token_char),
    .out_token_first (out_token_first),
    .out_token_last  (out_token_last),
    .out_line_number (out_line_number),
    .out_error_code  (out_error_code),
    .out_run_last    (out_run_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_config_text_lexer: FAIL");
    $finish;
  end

  // The receiver stalls at random, or for a long counted stretch when asked.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.kind       = kind_t'(out_token_kind);
      seen.char_valid = out_char_valid;
      seen.token_char = out_token_char;
      seen.first      = out_token_first;
      seen.last       = out_token_last;
      seen.line       = out_line_number;
      seen.err        = err_t'(out_error_code);
      seen.run_last   = out_run_last;
      book.match_token(seen);
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit eot);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.take_byte(b, eot);
    n_sent++;
  endtask

  task automatic send_src();
    foreach (src[i]) send_byte(src[i][7:0], src[i][8]);
    src.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (book.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void put_byte(logic [7:0] b);
    src.insert(src.size(), {1'b0, b});
  endfunction

  function automatic void put_end();
    src.insert(src.size(), {1'b1, 8'($urandom_range(255))});
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(1)) return 8'($urandom_range("z", "a"));
    return 8'($urandom_range("Z", "A"));
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  // Mostly uniform bytes, with the bytes that matter to strings made more likely.
  function automatic logic [7:0] pick_content();
    if ($urandom_range(3) != 0) return 8'($urandom_range(255));
    case ($urandom_range(5))
      0:       return CH_RBRACE;
      1:       return CH_BSLASH;
      2:       return CH_DQUOTE;
      3:       return CH_SQUOTE;
      4:       return CH_LBRACE;
      default: return CH_LF;
    endcase
  endfunction

  function automatic void add_blank();
    repeat ($urandom_range(3, 1)) begin
      case ($urandom_range(5))
        0:       put_byte(CH_SPACE);
        1:       put_byte(CH_TAB);
        2:       put_byte(CH_LF);
        3:       put_byte(CH_CR);
        4:       put_byte(8'h0B);
        default: put_byte(8'h0C);
      endcase
    end
  endfunction

  function automatic void add_comment();
    logic [7:0] b;
    if ($urandom_range(1)) push_str("#");
    else push_str("//");
    repeat ($urandom_range(6)) begin
      b = pick_content();
      put_byte(b == CH_LF ? CH_SPACE : b);
    end
    put_byte(CH_LF);
  endfunction

  function automatic void add_number();
    repeat ($urandom_range(4, 1)) put_byte(pick_digit());
    if ($urandom_range(2) == 0) begin
      put_byte(CH_DOT);
      repeat ($urandom_range(3, 1)) put_byte(pick_digit());
    end
  endfunction

  function automatic void add_name();
    put_byte(pick_letter());
    repeat ($urandom_range(5)) begin
      case ($urandom_range(9))
        0:       put_byte(CH_DASH);
        1:       put_byte(CH_DOLLAR);
        2:       put_byte(CH_UNDER);
        3, 4:    put_byte(pick_digit());
        default: put_byte(pick_letter());
      endcase
    end
  endfunction

  function automatic void add_quoted(logic [7:0] q);
    logic [7:0] b;
    put_byte(q);
    repeat ($urandom_range(6)) begin
      b = pick_content();
      if (b == q || b == CH_BSLASH || $urandom_range(7) == 0) put_byte(CH_BSLASH);
      put_byte(b);
    end
    put_byte(q);
  endfunction

  function automatic void add_braced();
    logic [7:0] body[$];
    repeat ($urandom_range(6)) body.insert(body.size(), pick_content());
    push_str("{{");
    foreach (body[i]) begin
      // A bare brace must not be read as the closing pair.
      if (body[i] == CH_BSLASH || $urandom_range(7) == 0 ||
          (body[i] == CH_RBRACE && (i == body.size() - 1 || body[i + 1] == CH_RBRACE)))
        put_byte(CH_BSLASH);
      put_byte(body[i]);
    end
    push_str("}}");
  endfunction

  function automatic void add_punct();
    case ($urandom_range(4))
      0: begin
        // Two open braces in a row would start a braced string.
        if (src.size() > 0 && src[src.size() - 1] == {1'b0, CH_LBRACE}) put_byte(CH_SPACE);
        put_byte(CH_LBRACE);
      end
      1:       put_byte(CH_RBRACE);
      2:       put_byte(CH_COLON);
      3:       put_byte(CH_COMMA);
      default: put_byte(CH_SEMI);
    endcase
  endfunction

  function automatic void add_document(int pieces);
    repeat (pieces) begin
      case ($urandom_range(9))
        0:       add_blank();
        1:       add_comment();
        2, 3:    add_number();
        4, 5:    add_name();
        6:       add_quoted(CH_DQUOTE);
        7:       add_quoted(CH_SQUOTE);
        8:       add_braced();
        default: add_punct();
      endcase
      if ($urandom_range(14) == 0) put_end();
    end
    put_end();
  endfunction

  function automatic logic [7:0] pick_stray();
    case ($urandom_range(7))
      0:       return "!";
      1:       return CH_DOT;
      2:       return CH_DASH;
      3:       return "@";
      4:       return CH_BSLASH;
      5:       return 8'h00;
      6:       return 8'h80;
      default: return 8'hFF;
    endcase
  endfunction

  initial begin
    int directed;
    int d;
    book           = new();
    send_gap_pct   = 0;
    stall_pct      = 0;
    hold_left      = 0;
    n_sent         = 0;
    cycle_count    = 0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_text_byte   <= 8'h00;
    in_end_of_text <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: comments, a dotted number, a name with a dash, an escaped quote,
    // a braced string with a lone brace inside, braces, and flushes at end of text.
    push_str("#");
    put_byte(8'h00);
    push_str("\n//\n1.2:a-9,\"\\\"\"{{");
    put_byte(8'hFF);
    push_str("}x}}{}");
    put_end();
    push_str("{");
    put_end();
    push_str("7");
    put_end();
    send_src();
    wait_drained();
    directed = n_sent;

    d = 0;
    while (n_sent - directed < RANDOM_ITEMS) begin
      case (d % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 62; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 62; end
        default: begin send_gap_pct = 9; stall_pct = 9; end
      endcase
      if (d == 5) begin
        // Keep offering bytes while the result side is held off.
        send_gap_pct = 0;
        hold_left    = 300;
      end
      add_document($urandom_range(12, 4));
      send_src();
      if (d % 4 == 3) wait_drained();
      d++;
    end
    wait_drained();

    // A short document on an idle lexer with both sides running freely.
    send_gap_pct = 0;
    stall_pct    = 0;
    push_str("ab 12;");
    put_end();
    send_src();
    wait_drained();

    // One error per run; everything after it must be swallowed.
    stall_pct = 9;
    push_str("x ");
    case ($urandom_range(7))
      0: put_byte(pick_stray());
      1: push_str("/x");
      2: push_str("7.;");
      3: begin push_str("\"ab"); put_end(); end
      4: begin push_str("'a\\"); put_end(); end
      5: begin push_str("{{a}"); put_end(); end
      6: begin push_str("/"); put_end(); end
      default: begin push_str("3."); put_end(); end
    endcase
    repeat (6) begin
      if ($urandom_range(1)) put_end();
      else put_byte(8'($urandom_range(255)));
    end
    send_src();
    wait_drained();

    $display("Lexed %0d source transactions (%0d directed), checked %0d token results.",
             n_sent, directed, book.n_checked);
    $display("Line counter ended at %0d; the run closed on error code %0d, %0d mismatches.",
             book.line, book.seen_err, book.n_bad);
    if (book.n_bad == 0 && book.due.size() == 0) begin
      $display("tb_config_text_lexer: PASS");
    end else begin
      $display("tb_config_text_lexer: FAIL");
    end
    $finish;
  end

endmodule
